// ===== hw/rtl/ffra_pkg.sv =====
// Shared types, constants and helper functions for the first-fit range allocator.
// Used by the interfaces, the table cells, the controller and the top level.
package ffra_pkg;

    localparam int MAX_RANGES_DEF = 64;
    localparam int MAX_ORDER      = 32;

    localparam int START_W  = 32;
    localparam int LEN_W    = 33;
    localparam int CUR_W    = 34;
    localparam int SUM_W    = 35;
    localparam int ORDER_W  = 6;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [ORDER_W-1:0] RESET_ORDER = ORDER_W'(16);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic REG_POOL_ORDER = 1'b0;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_TABLE_FULL = 3'd2,
        ST_NOT_FOUND  = 3'd3,
        ST_ZERO_SIZE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } entry_t;

    typedef struct packed {
        logic             clear;
        logic [LEN_W-1:0] clear_pool;
        logic [LEN_W-1:0] pool;
    } cfg_evt_t;

    function automatic logic [LEN_W-1:0] pool_bytes(input logic [ORDER_W-1:0] order);
        logic [ORDER_W-1:0] sat;
        sat = (order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order;
        return LEN_W'(1) << sat;
    endfunction

endpackage

// ===== hw/rtl/ffra_req_if.sv =====
// Request channel interface: valid/ready handshake with the request word.
// Depends on ffra_pkg for field widths.
interface ffra_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [ffra_pkg::LEN_W-1:0]   alloc_size;
    logic [ffra_pkg::START_W-1:0] free_offset;

    modport source (output valid, output action, output alloc_size, output free_offset,
                    input ready);
    modport sink (input valid, input action, input alloc_size, input free_offset,
                  output ready);
endinterface

// ===== hw/rtl/ffra_rsp_if.sv =====
// Response channel interface: valid/ready handshake with the result word.
// Depends on ffra_pkg for field widths.
interface ffra_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffra_pkg::STATUS_W-1:0] status;
    logic [ffra_pkg::START_W-1:0]  range_offset;
    logic [ffra_pkg::LEN_W-1:0]    bytes_free;

    modport source (output valid, output status, output range_offset, output bytes_free,
                    input ready);
    modport sink (input valid, input status, input range_offset, input bytes_free,
                  output ready);
endinterface

// ===== hw/rtl/ffra_cell.sv =====
// One cell of the range table ring: holds a start offset and a length and
// takes its neighbour's entry whenever the ring rotates. Depends on ffra_pkg.
module ffra_cell (
    input  logic             clk,
    input  logic             shift,
    input  ffra_pkg::entry_t nxt,
    output ffra_pkg::entry_t cur
);

    ffra_pkg::entry_t entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= nxt;
        end
    end

    assign cur = entry_reg;

endmodule

// ===== hw/rtl/ffra_ctrl.sv =====
// Controller for the allocator: request checks, one full rotation of the cell
// ring per request that passes them, with insertion or removal on the fly,
// and the result register. Depends on ffra_pkg, ffra_req_if and ffra_rsp_if.
module ffra_ctrl #(
    parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    ffra_req_if.sink           req,
    ffra_rsp_if.source         rsp,
    input  ffra_pkg::entry_t   head,
    input  ffra_pkg::entry_t   second,
    input  ffra_pkg::cfg_evt_t cfg,
    output ffra_pkg::entry_t   emit,
    output logic               shift
);

    localparam int IDX_W = $clog2(MAX_RANGES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int LEN_W = ffra_pkg::LEN_W;
    localparam int CUR_W = ffra_pkg::CUR_W;
    localparam int SUM_W = ffra_pkg::SUM_W;
    localparam int START_W = ffra_pkg::START_W;
    localparam logic [LEN_W-1:0] RESET_FREE = ffra_pkg::pool_bytes(ffra_pkg::RESET_ORDER);

    ffra_pkg::ctrl_state_t state_reg, state_next;
    logic [IDX_W-1:0]      step_reg, step_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]      free_reg, free_next;
    logic                  act_reg, act_next;
    logic [LEN_W-1:0]      size_reg, size_next;
    logic [START_W-1:0]    offset_reg, offset_next;
    logic [CUR_W-1:0]      cursor_reg, cursor_next;
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    ffra_pkg::entry_t      hold_reg, hold_next;
    ffra_pkg::status_t     status_reg, status_next;
    logic [START_W-1:0]    where_reg, where_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    ffra_pkg::status_t     rsp_status_reg, rsp_status_next;
    logic [START_W-1:0]    rsp_offset_reg, rsp_offset_next;
    logic [LEN_W-1:0]      rsp_free_reg, rsp_free_next;

    logic [SUM_W-1:0]      need_sum;
    logic                  head_fit;
    logic                  tail_fit;
    logic                  row_live;
    logic                  last_step;
    ffra_pkg::entry_t      new_entry;

    assign need_sum  = SUM_W'(cursor_reg) + SUM_W'(size_reg);
    assign head_fit  = SUM_W'(head.start) >= need_sum;
    assign tail_fit  = need_sum <= SUM_W'(cfg.pool);
    assign row_live  = CNT_W'(step_reg) < count_reg;
    assign last_step = step_reg == IDX_W'(MAX_RANGES - 1);
    assign new_entry = '{start: cursor_reg[START_W-1:0], len: size_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffra_pkg::CS_IDLE;
            count_reg     <= '0;
            free_reg      <= RESET_FREE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        act_reg        <= act_next;
        size_reg       <= size_next;
        offset_reg     <= offset_next;
        cursor_reg     <= cursor_next;
        done_reg       <= done_next;
        hit_reg        <= hit_next;
        hold_reg       <= hold_next;
        status_reg     <= status_next;
        where_reg      <= where_next;
        rsp_status_reg <= rsp_status_next;
        rsp_offset_reg <= rsp_offset_next;
        rsp_free_reg   <= rsp_free_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        act_next        = act_reg;
        size_next       = size_reg;
        offset_next     = offset_reg;
        cursor_next     = cursor_reg;
        done_next       = done_reg;
        hit_next        = hit_reg;
        hold_next       = hold_reg;
        status_next     = status_reg;
        where_next      = where_reg;
        rsp_status_next = rsp_status_reg;
        rsp_offset_next = rsp_offset_reg;
        rsp_free_next   = rsp_free_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        emit            = head;
        shift           = 1'b0;

        case (state_reg)
            ffra_pkg::CS_IDLE:
            begin
                act_next    = req.action;
                size_next   = req.alloc_size;
                offset_next = req.free_offset;
                step_next   = '0;
                cursor_next = '0;
                done_next   = 1'b0;
                hit_next    = 1'b0;
                where_next  = '0;
                if (req.valid)
                begin
                    if (req.action == ffra_pkg::ACT_FREE)
                    begin
                        status_next = ffra_pkg::ST_NOT_FOUND;
                        state_next  = ffra_pkg::CS_SCAN;
                    end
                    else if (req.alloc_size == '0)
                    begin
                        status_next = ffra_pkg::ST_ZERO_SIZE;
                        state_next  = ffra_pkg::CS_FINISH;
                    end
                    else if (req.alloc_size > free_reg)
                    begin
                        status_next = ffra_pkg::ST_NO_SPACE;
                        state_next  = ffra_pkg::CS_FINISH;
                    end
                    else if (count_reg >= CNT_W'(MAX_RANGES))
                    begin
                        status_next = ffra_pkg::ST_TABLE_FULL;
                        state_next  = ffra_pkg::CS_FINISH;
                    end
                    else
                    begin
                        status_next = ffra_pkg::ST_NO_SPACE;
                        state_next  = ffra_pkg::CS_SCAN;
                    end
                end
            end

            ffra_pkg::CS_SCAN:
            begin
                shift     = 1'b1;
                step_next = step_reg + IDX_W'(1);
                if (act_reg == ffra_pkg::ACT_FREE)
                begin
                    if (done_reg)
                    begin
                        emit = hit_reg ? second : head;
                    end
                    else if (row_live && head.start == offset_reg)
                    begin
                        emit        = second;
                        done_next   = 1'b1;
                        hit_next    = 1'b1;
                        status_next = ffra_pkg::ST_OK;
                        free_next   = LEN_W'(free_reg + head.len);
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                else
                begin
                    if (done_reg)
                    begin
                        if (hit_reg)
                        begin
                            emit      = hold_reg;
                            hold_next = head;
                        end
                    end
                    else if ((row_live && head_fit) || (!row_live && tail_fit))
                    begin
                        emit        = new_entry;
                        hold_next   = head;
                        done_next   = 1'b1;
                        hit_next    = 1'b1;
                        status_next = ffra_pkg::ST_OK;
                        where_next  = cursor_reg[START_W-1:0];
                        free_next   = free_reg - size_reg;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else if (row_live)
                    begin
                        cursor_next = CUR_W'(head.start) + CUR_W'(head.len);
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
                if (last_step)
                begin
                    state_next = ffra_pkg::CS_FINISH;
                end
            end

            ffra_pkg::CS_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_offset_next = where_reg;
                    rsp_free_next   = free_reg;
                    state_next      = ffra_pkg::CS_IDLE;
                end
            end

            default:
            begin
                state_next = ffra_pkg::CS_IDLE;
            end
        endcase

        if (cfg.clear)
        begin
            count_next = '0;
            free_next  = cfg.clear_pool;
        end
    end

    assign req.ready        = state_reg == ffra_pkg::CS_IDLE;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.range_offset = rsp_offset_reg;
    assign rsp.bytes_free   = rsp_free_reg;

endmodule

// ===== hw/rtl/first_fit_range_allocator.sv =====
// First-fit range allocator: a ring of MAX_RANGES table cells, a controller and the APB register.
// An allocate that fails its size or table checks is answered without rotating the ring;
// every other request rotates the whole cell ring once before it is answered.
// A new request is taken only in the idle state, after the previous result has gone to the response register.
// Reset: empty table, pool order 16 and 65536 free bytes; table contents are not cleared.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if, ffra_cell and ffra_ctrl.
module first_fit_range_allocator #(
    parameter int MAX_RANGES = ffra_pkg::MAX_RANGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    ffra_req_if.sink                      req,
    ffra_rsp_if.source                    rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ffra_pkg::PADDR_W-1:0]  paddr,
    input  logic [ffra_pkg::PDATA_W-1:0]  pwdata,
    output logic [ffra_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int ORDER_W = ffra_pkg::ORDER_W;

    logic [ORDER_W-1:0]  pool_order_reg, pool_order_next;
    logic                reg_wr;
    logic                sel_order;
    ffra_pkg::cfg_evt_t  cfg;
    ffra_pkg::entry_t    emit;
    logic                shift;
    ffra_pkg::entry_t    cells_cur [MAX_RANGES];

    assign pready    = 1'b1;
    assign sel_order = paddr[ffra_pkg::PADDR_W-1] == ffra_pkg::REG_POOL_ORDER;
    assign reg_wr    = psel && penable && pwrite && pready && sel_order;

    always_comb
    begin
        pool_order_next = pool_order_reg;
        if (reg_wr)
        begin
            pool_order_next = pwdata[ORDER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_order_reg <= ffra_pkg::RESET_ORDER;
        end
        else
        begin
            pool_order_reg <= pool_order_next;
        end
    end

    assign prdata = sel_order ? ffra_pkg::PDATA_W'(pool_order_reg) : '0;

    assign cfg.clear      = reg_wr;
    assign cfg.clear_pool = ffra_pkg::pool_bytes(pwdata[ORDER_W-1:0]);
    assign cfg.pool       = ffra_pkg::pool_bytes(pool_order_reg);

    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        if (i == MAX_RANGES - 1)
        begin : g_tail
            ffra_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .nxt   (emit),
                .cur   (cells_cur[i])
            );
        end
        else
        begin : g_body
            ffra_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .nxt   (cells_cur[i+1]),
                .cur   (cells_cur[i])
            );
        end
    end

    ffra_ctrl #(
        .MAX_RANGES (MAX_RANGES)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .head   (cells_cur[0]),
        .second (cells_cur[1]),
        .cfg    (cfg),
        .emit   (emit),
        .shift  (shift)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("Request channel still ready after taking a word.");

    a_failed_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ffra_pkg::ST_OK |-> rsp.range_offset == '0)
        else $error("Failed request returned a non-zero range offset.");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> !$past(req.ready))
        else $error("Result word appeared without a request in progress.");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for first_fit_range_allocator: predicts every reply word from its own
// model of the used-range table and compares it field by field with what the block returns.
// Depends on ffra_pkg, ffra_req_if, ffra_rsp_if and the first_fit_range_allocator RTL.
`timescale 1ns / 100ps

module testbench;
    import ffra_pkg::*;

    localparam int PERIOD       = 10;
    localparam int SLOTS        = MAX_RANGES_DEF;
    localparam int BOOK_SCORE   = 0;
    localparam int BOOK_PLAN    = 1;
    localparam int IDLE_PCT     = 24;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    localparam logic [PADDR_W-1:0] POOL_ORDER_ADDR = PADDR_W'(4 * REG_POOL_ORDER);
    localparam logic [PADDR_W-1:0] UNMAPPED_ADDR   = PADDR_W'(4);

    typedef struct packed {
        logic               action;
        logic [LEN_W-1:0]   size;
        logic [START_W-1:0] offset;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [START_W-1:0]  offset;
        logic [LEN_W-1:0]    free;
    } outcome_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    ffra_req_if req_ch ();
    ffra_rsp_if rsp_ch ();

    first_fit_range_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [START_W-1:0] seg_start [0:1][0:SLOTS-1];
    logic [LEN_W-1:0]   seg_len   [0:1][0:SLOTS-1];
    int                 seg_count [0:1];
    logic [LEN_W-1:0]   seg_free  [0:1];
    logic [ORDER_W-1:0] order_reg [0:1];

    request_t queued_requests[$];
    outcome_t owed_replies[$];
    request_t next_word;

    int   failures = 0;
    int   idle_pct = IDLE_PCT;
    bit   send_hold = 1'b0;
    int   hold_requests = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    logic req_took = 1'b0;

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    function automatic logic [63:0] pool_size(input int bk);
        return 64'd1 << ((order_reg[bk] > MAX_ORDER) ? MAX_ORDER : order_reg[bk]);
    endfunction

    function automatic void clear_pool(input int bk, input logic [ORDER_W-1:0] order);
        order_reg[bk] = order;
        seg_count[bk] = 0;
        seg_free[bk]  = LEN_W'(pool_size(bk));
    endfunction

    function automatic outcome_t serve_request(input int bk, input request_t rq);
        outcome_t    res;
        logic [63:0] cursor;
        logic [63:0] gap;
        logic [63:0] room;
        int          pos;
        int          hit;
        int          i;
        res.status = ST_OK;
        res.offset = '0;
        if (rq.action == ACT_ALLOC)
        begin
            if (rq.size == '0)
                res.status = ST_ZERO_SIZE;
            else if (rq.size > seg_free[bk])
                res.status = ST_NO_SPACE;
            else if (seg_count[bk] >= SLOTS)
                res.status = ST_TABLE_FULL;
            else
            begin
                cursor = '0;
                pos = seg_count[bk];
                for (i = 0; i < seg_count[bk] && pos == seg_count[bk]; i++)
                begin
                    gap = (64'(seg_start[bk][i]) >= cursor) ? 64'(seg_start[bk][i]) - cursor : '0;
                    if (gap >= 64'(rq.size))
                        pos = i;
                    else
                        cursor = 64'(seg_start[bk][i]) + 64'(seg_len[bk][i]);
                end
                room = (pool_size(bk) >= cursor) ? pool_size(bk) - cursor : '0;
                if (pos == seg_count[bk] && 64'(rq.size) > room)
                    res.status = ST_NO_SPACE;
                else
                begin
                    for (i = seg_count[bk]; i > pos; i--)
                    begin
                        seg_start[bk][i] = seg_start[bk][i-1];
                        seg_len[bk][i]   = seg_len[bk][i-1];
                    end
                    seg_start[bk][pos] = cursor[START_W-1:0];
                    seg_len[bk][pos]   = rq.size;
                    seg_count[bk]++;
                    seg_free[bk] = seg_free[bk] - rq.size;
                    res.offset = cursor[START_W-1:0];
                end
            end
        end
        else
        begin
            hit = seg_count[bk];
            for (i = 0; i < seg_count[bk] && hit == seg_count[bk]; i++)
            begin
                if (seg_start[bk][i] == rq.offset)
                    hit = i;
            end
            if (hit == seg_count[bk])
                res.status = ST_NOT_FOUND;
            else
            begin
                seg_free[bk] = seg_free[bk] + seg_len[bk][hit];
                for (i = hit; i + 1 < seg_count[bk]; i++)
                begin
                    seg_start[bk][i] = seg_start[bk][i+1];
                    seg_len[bk][i]   = seg_len[bk][i+1];
                end
                seg_count[bk]--;
            end
        end
        res.free = seg_free[bk];
        return res;
    endfunction

    task automatic queue_request(input logic act, input logic [LEN_W-1:0] size,
                                 input logic [START_W-1:0] offset);
        request_t rq;
        rq.action = act;
        rq.size   = (act == ACT_ALLOC) ? size : LEN_W'({$urandom, $urandom});
        rq.offset = (act == ACT_FREE) ? offset : START_W'($urandom);
        void'(serve_request(BOOK_PLAN, rq));
        queued_requests.push_back(rq);
    endtask

    task automatic random_requests(input int n);
        logic [63:0] pool;
        logic [63:0] span;
        int          k;
        int          pick;
        int          cnt;
        for (k = 0; k < n; k++)
        begin
            pool = pool_size(BOOK_PLAN);
            span = ((pool >> 3) != 0) ? (pool >> 3) : 64'd1;
            cnt  = seg_count[BOOK_PLAN];
            pick = $urandom_range(99);
            if (pick >= 40 && pick < 75 && cnt != 0)
                queue_request(ACT_FREE, '0, seg_start[BOOK_PLAN][$urandom_range(cnt - 1)]);
            else if (pick >= 75 && pick < 85)
            begin
                if (cnt != 0 && $urandom_range(1) == 1)
                    queue_request(ACT_FREE, '0, seg_start[BOOK_PLAN][$urandom_range(cnt - 1)] + 1);
                else
                    queue_request(ACT_FREE, '0, START_W'($urandom));
            end
            else if (pick >= 85 && pick < 90)
                queue_request(ACT_ALLOC, '0, '0);
            else if (pick >= 90 && pick < 95)
                queue_request(ACT_ALLOC, LEN_W'({$urandom, $urandom}), '0);
            else if (pick >= 95)
                queue_request(ACT_ALLOC, seg_free[BOOK_PLAN], '0);
            else if ($urandom_range(9) < 6)
                queue_request(ACT_ALLOC, LEN_W'(64'd1 + (64'($urandom) % span)), '0);
            else if ($urandom_range(1) == 0)
                queue_request(ACT_ALLOC, LEN_W'($urandom_range(8, 1)), '0);
            else
                queue_request(ACT_ALLOC, LEN_W'(64'd1 + ({$urandom, $urandom} % pool)), '0);
        end
    endtask

    task automatic wait_drained();
        while (queued_requests.size() != 0 || req_ch.valid || owed_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == POOL_ORDER_ADDR)
        begin
            if (prdata !== PDATA_W'(value[ORDER_W-1:0]))
            begin
                if (failures < 10)
                    $display("pool_order read back %h, expected %h", prdata,
                             PDATA_W'(value[ORDER_W-1:0]));
                failures++;
            end
            clear_pool(BOOK_SCORE, value[ORDER_W-1:0]);
            clear_pool(BOOK_PLAN, value[ORDER_W-1:0]);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_took)
        begin
            if (queued_requests.size() != 0 && !send_hold && $urandom_range(99) >= idle_pct)
            begin
                next_word = queued_requests.pop_front();
                req_ch.action      <= next_word.action;
                req_ch.alloc_size  <= next_word.size;
                req_ch.free_offset <= next_word.offset;
                req_ch.valid       <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge clk)
    begin : reply_check
        outcome_t want;
        outcome_t got;
        request_t taken;
        if (!rst_n)
            req_took <= 1'b0;
        else
        begin
            req_took <= req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status = rsp_ch.status;
                got.offset = rsp_ch.range_offset;
                got.free   = rsp_ch.bytes_free;
                if (owed_replies.size() == 0)
                begin
                    if (failures < 10)
                        $display("unexpected reply: status %0d offset %h free %h",
                                 got.status, got.offset, got.free);
                    failures++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (got.status !== want.status || got.offset !== want.offset ||
                        got.free !== want.free)
                    begin
                        if (failures < 10)
                            $display("reply mismatch: status %0d/%0d offset %h/%h free %h/%h",
                                     want.status, got.status, want.offset, got.offset,
                                     want.free, got.free);
                        failures++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                taken.action = req_ch.action;
                taken.size   = req_ch.alloc_size;
                taken.offset = req_ch.free_offset;
                owed_replies.push_back(serve_request(BOOK_SCORE, taken));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL first_fit_range_allocator");
            $finish;
        end
    end

    initial
    begin : stimulus
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_ALLOC;
        req_ch.alloc_size  = '0;
        req_ch.free_offset = '0;
        rsp_ch.ready       = 1'b0;
        clear_pool(BOOK_SCORE, RESET_ORDER);
        clear_pool(BOOK_PLAN, RESET_ORDER);
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Boundary sizes and offsets, gap reuse, exact tail fit and a fragmented pool.
        queue_request(ACT_ALLOC, LEN_W'(0), '0);
        queue_request(ACT_ALLOC, LEN_W'(65537), '0);
        queue_request(ACT_ALLOC, LEN_W'(64'h1_0000_0000), '0);
        queue_request(ACT_ALLOC, '1, '0);
        queue_request(ACT_FREE, '0, START_W'(0));
        queue_request(ACT_ALLOC, LEN_W'(100), '0);
        queue_request(ACT_ALLOC, LEN_W'(200), '0);
        queue_request(ACT_ALLOC, LEN_W'(300), '0);
        queue_request(ACT_FREE, '0, START_W'(100));
        queue_request(ACT_ALLOC, LEN_W'(50), '0);
        queue_request(ACT_ALLOC, LEN_W'(150), '0);
        queue_request(ACT_ALLOC, LEN_W'(64936), '0);
        queue_request(ACT_ALLOC, LEN_W'(1), '0);
        queue_request(ACT_FREE, '0, START_W'(600));
        queue_request(ACT_FREE, '0, '1);
        queue_request(ACT_FREE, '0, START_W'(1));
        queue_request(ACT_FREE, '0, START_W'(0));
        queue_request(ACT_ALLOC, LEN_W'(100), '0);
        queue_request(ACT_FREE, '0, START_W'(100));
        queue_request(ACT_ALLOC, LEN_W'(64986), '0);
        queue_request(ACT_ALLOC, LEN_W'(64936), '0);
        queue_request(ACT_FREE, '0, START_W'(300));
        queue_request(ACT_ALLOC, LEN_W'(200), '0);
        random_requests(150);

        set_register(UNMAPPED_ADDR, PDATA_W'(5));
        random_requests(50);

        set_register(POOL_ORDER_ADDR, PDATA_W'(12));
        while (seg_count[BOOK_PLAN] < SLOTS)
            queue_request(ACT_ALLOC, LEN_W'($urandom_range(4, 1)), '0);
        queue_request(ACT_ALLOC, LEN_W'(0), '0);
        queue_request(ACT_ALLOC, seg_free[BOOK_PLAN] + 1, '0);
        queue_request(ACT_ALLOC, LEN_W'(1), '0);
        queue_request(ACT_ALLOC, LEN_W'(2), '0);
        random_requests(150);

        set_register(POOL_ORDER_ADDR, PDATA_W'(0));
        random_requests(40);

        wait_drained();
        idle_pct = 0;
        set_register(POOL_ORDER_ADDR, PDATA_W'(MAX_ORDER));
        random_requests(200);
        wait_drained();
        idle_pct = IDLE_PCT;

        set_register(POOL_ORDER_ADDR, PDATA_W'(63));
        random_requests(150);

        set_register(POOL_ORDER_ADDR, 32'hFFFF_FFC6);
        random_requests(200);

        set_register(POOL_ORDER_ADDR, PDATA_W'(20));
        random_requests(200);
        while (queued_requests.size() > 190)
            @(posedge clk);
        hold_requests++;

        set_register(POOL_ORDER_ADDR, PDATA_W'(1));
        random_requests(60);

        set_register(POOL_ORDER_ADDR, PDATA_W'(40));
        random_requests(150);

        set_register(POOL_ORDER_ADDR, PDATA_W'(3));
        random_requests(100);

        set_register(POOL_ORDER_ADDR, PDATA_W'(24));
        random_requests(200);
        while (queued_requests.size() > 100)
            @(posedge clk);
        send_hold = 1'b1;
        while (req_ch.valid || owed_replies.size() != 0)
            @(posedge clk);
        send_hold = 1'b0;

        set_register(POOL_ORDER_ADDR, PDATA_W'(RESET_ORDER));
        random_requests(200);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("PASS first_fit_range_allocator");
        else
            $display("FAIL first_fit_range_allocator");
        $finish;
    end

endmodule
